### src/mbrf_pkg.sv
// package: sequencer control word, request program table and crc helper
`default_nettype none
package mbrf_pkg;

	localparam int MAX_WRITE_REGS_DEF = 16;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [7:0]  SLAVE_RESET = 8'h01;

	localparam logic [7:0] FN_COIL  = 8'h05;
	localparam logic [7:0] FN_REG   = 8'h06;
	localparam logic [7:0] FN_MULTI = 8'h10;
	localparam logic [7:0] FN_READ  = 8'h03;
	localparam logic [7:0] COIL_ON  = 8'hFF;

	localparam int PC_W = 6;

	typedef logic [PC_W-1:0] pc_t;

	// program entry points
	localparam pc_t PC_COIL  = 6'd0;
	localparam pc_t PC_REG   = 6'd8;
	localparam pc_t PC_MULTI = 6'd16;
	localparam pc_t PC_VALUE = 6'd23;
	localparam pc_t PC_READ  = 6'd27;

	typedef enum logic [1:0] {
		MODE_COIL  = 2'd0,
		MODE_REG   = 2'd1,
		MODE_MULTI = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		SRC_SLAVE,
		SRC_CONST,
		SRC_REG_H,
		SRC_REG_L,
		SRC_VAL_H,
		SRC_VAL_L,
		SRC_COIL,
		SRC_QTY,
		SRC_QTY2,
		SRC_CRC_L,
		SRC_CRC_H
	} src_t;

	typedef struct packed {
		src_t       src;
		logic [7:0] konst;  // byte for SRC_CONST
		logic       fin;    // final byte of the frame, stop
		logic       cend;   // stop here if more values are still to come
	} ctrl_word_t;

	function automatic ctrl_word_t cw(src_t s, logic [7:0] k, logic f, logic c);
		ctrl_word_t w;
		w.src = s;
		w.konst = k;
		w.fin = f;
		w.cend = c;
		return w;
	endfunction

	function automatic ctrl_word_t rom(pc_t pc);
		ctrl_word_t w;
		unique case (pc)
			// write single coil
			6'd0:  w = cw(SRC_SLAVE, 8'h00, 1'b0, 1'b0);
			6'd1:  w = cw(SRC_CONST, FN_COIL, 1'b0, 1'b0);
			6'd2:  w = cw(SRC_REG_H, 8'h00, 1'b0, 1'b0);
			6'd3:  w = cw(SRC_REG_L, 8'h00, 1'b0, 1'b0);
			6'd4:  w = cw(SRC_COIL, 8'h00, 1'b0, 1'b0);
			6'd5:  w = cw(SRC_CONST, 8'h00, 1'b0, 1'b0);
			6'd6:  w = cw(SRC_CRC_L, 8'h00, 1'b0, 1'b0);
			6'd7:  w = cw(SRC_CRC_H, 8'h00, 1'b1, 1'b0);
			// write single register
			6'd8:  w = cw(SRC_SLAVE, 8'h00, 1'b0, 1'b0);
			6'd9:  w = cw(SRC_CONST, FN_REG, 1'b0, 1'b0);
			6'd10: w = cw(SRC_REG_H, 8'h00, 1'b0, 1'b0);
			6'd11: w = cw(SRC_REG_L, 8'h00, 1'b0, 1'b0);
			6'd12: w = cw(SRC_VAL_H, 8'h00, 1'b0, 1'b0);
			6'd13: w = cw(SRC_VAL_L, 8'h00, 1'b0, 1'b0);
			6'd14: w = cw(SRC_CRC_L, 8'h00, 1'b0, 1'b0);
			6'd15: w = cw(SRC_CRC_H, 8'h00, 1'b1, 1'b0);
			// write multiple header, falls through into the value program
			6'd16: w = cw(SRC_SLAVE, 8'h00, 1'b0, 1'b0);
			6'd17: w = cw(SRC_CONST, FN_MULTI, 1'b0, 1'b0);
			6'd18: w = cw(SRC_REG_H, 8'h00, 1'b0, 1'b0);
			6'd19: w = cw(SRC_REG_L, 8'h00, 1'b0, 1'b0);
			6'd20: w = cw(SRC_CONST, 8'h00, 1'b0, 1'b0);
			6'd21: w = cw(SRC_QTY, 8'h00, 1'b0, 1'b0);
			6'd22: w = cw(SRC_QTY2, 8'h00, 1'b0, 1'b0);
			// one value of a write multiple
			6'd23: w = cw(SRC_VAL_H, 8'h00, 1'b0, 1'b0);
			6'd24: w = cw(SRC_VAL_L, 8'h00, 1'b0, 1'b1);
			6'd25: w = cw(SRC_CRC_L, 8'h00, 1'b0, 1'b0);
			6'd26: w = cw(SRC_CRC_H, 8'h00, 1'b1, 1'b0);
			// read holding registers
			6'd27: w = cw(SRC_SLAVE, 8'h00, 1'b0, 1'b0);
			6'd28: w = cw(SRC_CONST, FN_READ, 1'b0, 1'b0);
			6'd29: w = cw(SRC_REG_H, 8'h00, 1'b0, 1'b0);
			6'd30: w = cw(SRC_REG_L, 8'h00, 1'b0, 1'b0);
			6'd31: w = cw(SRC_CONST, 8'h00, 1'b0, 1'b0);
			6'd32: w = cw(SRC_QTY, 8'h00, 1'b0, 1'b0);
			6'd33: w = cw(SRC_CRC_L, 8'h00, 1'b0, 1'b0);
			6'd34: w = cw(SRC_CRC_H, 8'h00, 1'b1, 1'b0);
			default: w = cw(SRC_CONST, 8'h00, 1'b1, 1'b0);
		endcase
		return w;
	endfunction

	// one byte through the reflected crc-16, eight bit steps
	function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### src/modbus_rtu_request_framer.sv
// top level: modbus rtu master request framer with appended crc-16
//
// channel   direction  signals                                            transfer
// in        input      in_valid/in_ready, mode, register_address,         in_valid & in_ready
//                      quantity, register_value
// out       output     out_valid/out_ready, frame_byte, last_of_frame     out_valid & out_ready
// cfg       input      slave_address_we, slave_address_wdata              slave_address_we
//
// after an item is taken, one frame byte follows per cycle while out_ready holds:
// 8 bytes for coil, register and read frames, 9 or 11 for a write-multiple start,
// 2 or 4 for each later value; a dropped item or a swallowed value emits no byte.
// the rate is set by the sequencer stepping one control word per byte.
// reset clears the sequencer, the crc to 0xffff and the slave address to 1.
// a stalled out_ready freezes the step counter; the input waits until the sequencer stops.
`default_nettype none
module modbus_rtu_request_framer #(
	parameter int MAX_WRITE_REGS = mbrf_pkg::MAX_WRITE_REGS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        slave_address_we,
	input  wire logic [7:0]  slave_address_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] register_address,
	input  wire logic [7:0]  quantity,
	input  wire logic [15:0] register_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       frame_byte,
	output logic             last_of_frame
);
	import mbrf_pkg::*;

	// limit held in the width of quantity
	localparam logic [7:0] MAX_QTY = 8'(MAX_WRITE_REGS);

	// control and configuration state
	logic [7:0]  slave_q;
	logic        running_q;
	pc_t         pc_q;
	logic [15:0] crc_q;
	logic [7:0]  remaining_q;
	logic        dropping_q;

	// latched request fields
	logic [15:0] reg_q;
	logic [7:0]  qty_q;
	logic [15:0] val_q;

	// output register
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic        in_xfer;
	logic        step;      // sequencer emits a byte this cycle
	ctrl_word_t  cw_now;
	logic [7:0]  byte_d;
	logic [15:0] crc_base;
	logic [15:0] crc_d;
	logic        stop;
	logic [16:0] end_addr;
	logic        bad_multi;
	logic [7:0]  qty_m1;
	logic [7:0]  rem_m1;

	assign in_ready      = !running_q;
	assign in_xfer       = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign frame_byte    = byte_q;
	assign last_of_frame = last_q;

	// microcode fetch; the output slot must be free or draining
	assign cw_now = rom(pc_q);
	assign step   = running_q && (!out_valid_q || out_ready);

	// byte datapath
	always_comb begin
		unique case (cw_now.src)
			SRC_SLAVE: byte_d = slave_q;
			SRC_CONST: byte_d = cw_now.konst;
			SRC_REG_H: byte_d = reg_q[15:8];
			SRC_REG_L: byte_d = reg_q[7:0];
			SRC_VAL_H: byte_d = val_q[15:8];
			SRC_VAL_L: byte_d = val_q[7:0];
			SRC_COIL:  byte_d = (val_q != 16'h0000) ? COIL_ON : 8'h00;
			SRC_QTY:   byte_d = qty_q;
			SRC_QTY2:  byte_d = {qty_q[6:0], 1'b0};
			SRC_CRC_L: byte_d = crc_q[7:0];
			SRC_CRC_H: byte_d = crc_q[15:8];
			default:   byte_d = 8'h00;
		endcase
	end

	// crc restarts on the address byte, holds over the crc bytes, rearms after them
	assign crc_base = (cw_now.src == SRC_SLAVE) ? CRC_INIT : crc_q;
	always_comb begin
		unique case (cw_now.src)
			SRC_CRC_L: crc_d = crc_q;
			SRC_CRC_H: crc_d = CRC_INIT;
			default:   crc_d = crc_byte(crc_base, byte_d);
		endcase
	end

	// end of program, or conditional stop while values remain
	assign stop = cw_now.fin || (cw_now.cend && (remaining_q != 8'h00));

	// write-multiple screening
	assign end_addr  = {1'b0, register_address} + {9'h000, quantity};
	assign bad_multi = (end_addr > 17'h0FFFF) || (quantity > MAX_QTY);
	assign qty_m1    = quantity - 8'd1;
	assign rem_m1    = remaining_q - 8'd1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= SLAVE_RESET;
		end else if (slave_address_we) begin
			slave_q <= slave_address_wdata;
		end
	end

	// request fields, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			reg_q <= register_address;
			qty_q <= quantity;
			val_q <= register_value;
		end
	end

	// sequencer and item bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			pc_q        <= PC_COIL;
			crc_q       <= CRC_INIT;
			remaining_q <= 8'h00;
			dropping_q  <= 1'b0;
		end else if (in_xfer) begin
			if (remaining_q != 8'h00) begin
				// next value of a write multiple
				remaining_q <= rem_m1;
				if (dropping_q) begin
					if (rem_m1 == 8'h00) begin
						dropping_q <= 1'b0;
					end
				end else begin
					running_q <= 1'b1;
					pc_q      <= PC_VALUE;
				end
			end else begin
				unique case (mode_t'(mode))
					MODE_COIL: begin
						running_q <= 1'b1;
						pc_q      <= PC_COIL;
					end
					MODE_REG: begin
						running_q <= 1'b1;
						pc_q      <= PC_REG;
					end
					MODE_READ: begin
						running_q <= 1'b1;
						pc_q      <= PC_READ;
					end
					MODE_MULTI: begin
						// count zero is dropped with nothing to swallow
						if (quantity != 8'h00) begin
							remaining_q <= qty_m1;
							if (bad_multi) begin
								dropping_q <= (qty_m1 != 8'h00);
							end else begin
								dropping_q <= 1'b0;
								running_q  <= 1'b1;
								pc_q       <= PC_MULTI;
							end
						end
					end
					default: begin
						running_q <= 1'b0;
					end
				endcase
			end
		end else if (step) begin
			crc_q <= crc_d;
			if (stop) begin
				running_q <= 1'b0;
			end else begin
				pc_q <= pc_q + pc_t'(1);
			end
		end
	end

	// output register, filled by the sequencer, emptied by the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			byte_q <= byte_d;
			last_q <= cw_now.fin;
		end
	end

endmodule
`default_nettype wire
